// File: rtl/core/nmdlm_pkg.sv
`default_nettype none
package nmdlm_pkg;

   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int LEVEL_W = 13;
   localparam int LOG_W   = 22;
   localparam int SUM_W   = 48;

   localparam logic signed [LEVEL_W-1:0] FLOOR_DB16 = -13'sd2400;
   localparam logic signed [15:0]        CAL_DB16   = 16'sd352;
   localparam logic signed [MUL_W-1:0]   DB16_PER_LOG2 = 33'sd3156528;

   localparam logic [2:0] CSR_PHASE_STEP = 3'd0;
   localparam logic [2:0] CSR_OFFSET     = 3'd1;
   localparam logic [2:0] CSR_PB_LOW     = 3'd2;
   localparam logic [2:0] CSR_PB_HIGH    = 3'd3;
   localparam logic [2:0] CSR_FRAME_LEN  = 3'd4;

   typedef logic signed [MUL_W-1:0]  mul_op_type;
   typedef logic signed [PROD_W-1:0] mul_prod_type;

   // sine table entry, quarter-wave symmetry and odd taylor series in q30
   function automatic logic signed [15:0] sin_entry(input int unsigned idx,
                                                    input int unsigned abits);
      longint unsigned q;
      longint unsigned quad;
      longint unsigned r;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned f;
      longint unsigned s;
      longint unsigned one;
      logic signed [15:0] v;
      q    = 64'd1 << (abits - 2);
      one  = 64'd1 << 30;
      r    = idx & ((64'd1 << abits) - 1);
      quad = r >> (abits - 2);
      r    = r & (q - 1);
      if (quad[0]) r = q - r;
      t  = (r * 64'd1686629713) >> (abits - 2);
      t2 = (t * t) >> 30;
      f  = one - t2 / 110;
      f  = one - ((t2 * f) >> 30) / 72;
      f  = one - ((t2 * f) >> 30) / 42;
      f  = one - ((t2 * f) >> 30) / 20;
      f  = one - ((t2 * f) >> 30) / 6;
      s  = (t * f) >> 30;
      s  = (s + (64'd1 << 14)) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      v = 16'(s);
      if (quad >= 2) v = -v;
      return v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/nco_mixer_decimator_level_meter.sv
`default_nettype none
// channel | direction | tdata (low bit up)                         | tlast
// req_    | in        | sig_i, sig_q, noise_i, noise_q             | -
// rsp_    | out       | audio_sample, level_dbm                    | frame_end
// csr_    | in        | write enable, index, data (no read-back)   | -
// each sample goes through read, cos multiply, sin multiply and mix; an emitted one also square,
// accumulate and output; the shared multiplier does both mixer products and the square in turn.
// on a frame end with a nonzero sum the level meter takes logs of sum and length (16 squarings
// each, after a left shift until the msb is set), then a scaling multiply and a level write.
// reset is synchronous; a result waiting in rsp_ holds the sequencer in its output state until taken.
module nco_mixer_decimator_level_meter
   import nmdlm_pkg::*;
#(
   parameter int DECIMATION    = 8,
   parameter int LUT_ADDR_BITS = 10,
   parameter int SAMPLE_BITS   = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   // sig_i, sig_q, noise_i, noise_q, zero pad
   input  wire [((4 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   // audio_sample, level_dbm, zero pad
   output logic [((SAMPLE_BITS + 1 + LEVEL_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                rsp_tlast,
   input  wire                 csr_wen,
   input  wire [2:0]           csr_addr,
   input  wire [31:0]          csr_wdata
);

   localparam int SB     = SAMPLE_BITS;
   localparam int AUD_W  = SB + 1;
   localparam int RSP_W  = ((AUD_W + LEVEL_W + 7) / 8) * 8;
   localparam int DEC_W  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
   localparam int MIX_W  = SB + 18;
   localparam logic [DEC_W-1:0] DEC_LAST = DEC_W'(DECIMATION - 1);
   localparam logic [LUT_ADDR_BITS-1:0] QUARTER = LUT_ADDR_BITS'(1 << (LUT_ADDR_BITS - 2));
   localparam logic signed [24:0] GAIN_OFF = 25'sd65536 * 25'(2 * (SB - 1));

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RDC  = 4'd1;
   localparam logic [3:0] ST_MULC = 4'd2;
   localparam logic [3:0] ST_MULS = 4'd3;
   localparam logic [3:0] ST_MIX  = 4'd4;
   localparam logic [3:0] ST_SQ   = 4'd5;
   localparam logic [3:0] ST_SQA  = 4'd6;
   localparam logic [3:0] ST_NORM = 4'd7;
   localparam logic [3:0] ST_SQR  = 4'd8;
   localparam logic [3:0] ST_SQRW = 4'd9;
   localparam logic [3:0] ST_DMUL = 4'd10;
   localparam logic [3:0] ST_DW   = 4'd11;
   localparam logic [3:0] ST_OUT  = 4'd12;

   logic [31:0]        phase_step_ff;
   logic signed [18:0] offset_ff;
   logic signed [15:0] pb_low_ff;
   logic signed [15:0] pb_high_ff;
   logic [15:0]        frame_len_ff;

   logic [3:0]  state_ff, state_in;
   logic [31:0] phase_ff;
   logic [DEC_W-1:0] decim_ff;
   logic [15:0] frame_cnt_ff;
   logic [SUM_W-1:0] sum_ff;
   logic signed [LEVEL_W-1:0] level_ff;
   logic [LUT_ADDR_BITS-1:0] idx_ff;
   logic signed [SB-1:0] xi_ff, xq_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [AUD_W-1:0] mixed_ff;
   logic fend_ff;
   logic [SUM_W-1:0] norm_ff;
   logic [5:0] msb_ff;
   logic [31:0] y_ff;
   logic [15:0] frac_ff;
   logic [3:0] step_ff;
   logic second_ff;
   logic [LOG_W-1:0] la_ff;
   logic signed [24:0] d_ff;

   logic [AUD_W-1:0] rsp_audio_ff;
   logic signed [LEVEL_W-1:0] rsp_level_ff;

   logic [LUT_ADDR_BITS-1:0] tbl_addr;
   logic signed [15:0] tbl_data;
   mul_op_type op_a, op_b;
   mul_prod_type prod;

   nmdlm_sine #(.LUT_ADDR_BITS(LUT_ADDR_BITS)) u_sine (
      .clock   (clock),
      .addr    (tbl_addr),
      .data_ff (tbl_data)
   );

   nmdlm_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   logic in_band;
   logic accept;
   logic out_free;
   logic signed [MIX_W-1:0] mix_sum;
   logic [SUM_W:0] sum_add;
   logic [SUM_W-1:0] sum_new;
   logic [15:0] len_eff;
   logic [16:0] cnt_next;
   logic frame_done;
   logic [32:0] y_sq;
   logic signed [15:0] lvl_raw;
   logic signed [15:0] lvl_cal;

   assign in_band = (offset_ff >= 19'(pb_low_ff)) && (offset_ff <= 19'(pb_high_ff));
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid || rsp_tready;

   assign mix_sum = MIX_W'(acc_ff) + MIX_W'(prod) + MIX_W'(1 << 14);
   assign sum_add = {1'b0, sum_ff} + {1'b0, prod[SUM_W-1:0]};
   assign sum_new = ((|prod[PROD_W-1:SUM_W]) || sum_add[SUM_W]) ? {SUM_W{1'b1}}
                                                               : sum_add[SUM_W-1:0];
   assign len_eff = (frame_len_ff == 16'd0) ? 16'd1 : frame_len_ff;
   assign cnt_next = {1'b0, frame_cnt_ff} + 17'd1;
   assign frame_done = cnt_next >= {1'b0, len_eff};
   assign y_sq = prod[63:31];
   // round half up of d*k / 2^32
   assign lvl_raw = 16'((prod + PROD_W'(64'sd1 << 31)) >>> 32);
   assign lvl_cal = lvl_raw - CAL_DB16;

   always_comb begin
      tbl_addr = idx_ff;
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_RDC: tbl_addr = idx_ff + QUARTER;
         ST_MULC: begin
            op_a = MUL_W'(xi_ff);
            op_b = MUL_W'(tbl_data);
         end
         ST_MULS: begin
            op_a = MUL_W'(xq_ff);
            op_b = MUL_W'(tbl_data);
         end
         ST_SQ: begin
            op_a = MUL_W'(mixed_ff);
            op_b = MUL_W'(mixed_ff);
         end
         ST_SQR: begin
            op_a = MUL_W'({1'b0, y_ff});
            op_b = MUL_W'({1'b0, y_ff});
         end
         ST_DMUL: begin
            op_a = MUL_W'(d_ff);
            op_b = DB16_PER_LOG2;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RDC;
         ST_RDC:  state_in = ST_MULC;
         ST_MULC: state_in = ST_MULS;
         ST_MULS: state_in = ST_MIX;
         ST_MIX:  state_in = (decim_ff == DEC_LAST) ? ST_SQ : ST_IDLE;
         ST_SQ:   state_in = ST_SQA;
         ST_SQA: begin
            if (frame_done && sum_new != '0) state_in = ST_NORM;
            else state_in = ST_OUT;
         end
         ST_NORM: if (norm_ff[SUM_W-1]) state_in = ST_SQR;
         ST_SQR:  state_in = ST_SQRW;
         ST_SQRW: begin
            if (step_ff != 4'd0) state_in = ST_SQR;
            else if (!second_ff) state_in = ST_NORM;
            else state_in = ST_DMUL;
         end
         ST_DMUL: state_in = ST_DW;
         ST_DW:   state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_step_ff <= '0;
         offset_ff     <= '0;
         pb_low_ff     <= '0;
         pb_high_ff    <= 16'sd3000;
         frame_len_ff  <= 16'd256;
         phase_ff      <= '0;
         decim_ff      <= '0;
         frame_cnt_ff  <= '0;
         sum_ff        <= '0;
         level_ff      <= FLOOR_DB16;
         rsp_tvalid    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            case (csr_addr)
               CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
               CSR_OFFSET:     offset_ff     <= csr_wdata[18:0];
               CSR_PB_LOW:     pb_low_ff     <= csr_wdata[15:0];
               CSR_PB_HIGH:    pb_high_ff    <= csr_wdata[15:0];
               CSR_FRAME_LEN:  frame_len_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && out_free) rsp_tvalid <= 1'b1;
         else if (rsp_tvalid && rsp_tready) rsp_tvalid <= 1'b0;
         case (state_ff)
            ST_IDLE: if (accept) phase_ff <= phase_ff + phase_step_ff;
            ST_MIX: decim_ff <= (decim_ff == DEC_LAST) ? '0 : decim_ff + DEC_W'(1);
            ST_SQA: begin
               sum_ff <= sum_new;
               if (frame_done) begin
                  frame_cnt_ff <= '0;
                  if (sum_new == '0) level_ff <= FLOOR_DB16;
               end else begin
                  frame_cnt_ff <= cnt_next[15:0];
               end
            end
            ST_DW: begin
               if (lvl_cal < 16'(FLOOR_DB16)) level_ff <= FLOOR_DB16;
               else level_ff <= lvl_cal[LEVEL_W-1:0];
            end
            ST_OUT: begin
               if (out_free && fend_ff) sum_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            idx_ff <= phase_ff[31 -: LUT_ADDR_BITS];
            if (in_band) begin
               xi_ff <= req_tdata[SB-1:0];
               xq_ff <= req_tdata[2*SB-1:SB];
            end else begin
               xi_ff <= req_tdata[3*SB-1:2*SB];
               xq_ff <= req_tdata[4*SB-1:3*SB];
            end
         end
         ST_MIX: begin
            acc_ff   <= acc_ff;
            mixed_ff <= AUD_W'(mix_sum >>> 15);
         end
         ST_MULS: acc_ff <= prod;
         ST_SQA: begin
            fend_ff   <= frame_done;
            norm_ff   <= sum_new;
            msb_ff    <= 6'(SUM_W - 1);
            second_ff <= 1'b0;
         end
         ST_NORM: begin
            if (norm_ff[SUM_W-1]) begin
               y_ff    <= norm_ff[SUM_W-1 -: 32];
               frac_ff <= '0;
               step_ff <= 4'd15;
            end else begin
               norm_ff <= {norm_ff[SUM_W-2:0], 1'b0};
               msb_ff  <= msb_ff - 6'd1;
            end
         end
         ST_SQRW: begin
            if (y_sq[32]) begin
               y_ff <= y_sq[32:1];
               frac_ff[step_ff] <= 1'b1;
            end else begin
               y_ff <= y_sq[31:0];
            end
            step_ff <= step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               if (!second_ff) begin
                  la_ff     <= {msb_ff, frac_ff[15:1], frac_ff[0] | y_sq[32]};
                  norm_ff   <= {len_eff, {(SUM_W-16){1'b0}}};
                  msb_ff    <= 6'd15;
                  second_ff <= 1'b1;
               end else begin
                  d_ff <= 25'(la_ff) - 25'({msb_ff, frac_ff[15:1], frac_ff[0] | y_sq[32]})
                          - GAIN_OFF;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_audio_ff <= mixed_ff;
               rsp_level_ff <= level_ff;
               rsp_tlast    <= fend_ff;
            end
         end
         default: ;
      endcase
   end

   // len (1..65535) is normalized inside the top 16 bits, msb counts from 15
   assign rsp_tdata = RSP_W'({rsp_level_ff, rsp_audio_ff});

endmodule
`default_nettype wire

// File: rtl/core/nmdlm_sine.sv
`default_nettype none
module nmdlm_sine
   import nmdlm_pkg::*;
#(
   parameter int LUT_ADDR_BITS = 10
) (
   input  wire                     clock,
   input  wire [LUT_ADDR_BITS-1:0] addr,
   output logic signed [15:0]      data_ff
);

   localparam int DEPTH = 1 << LUT_ADDR_BITS;

   logic signed [15:0] rom [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_rom
      localparam logic signed [15:0] ENTRY = sin_entry(i, LUT_ADDR_BITS);
      assign rom[i] = ENTRY;
   end

   always_ff @(posedge clock) begin
      data_ff <= rom[addr];
   end

endmodule
`default_nettype wire

// File: rtl/core/nmdlm_mul.sv
`default_nettype none
module nmdlm_mul
   import nmdlm_pkg::*;
(
   input  wire          clock,
   input  mul_op_type   op_a,
   input  mul_op_type   op_b,
   output mul_prod_type prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule
`default_nettype wire
